@@ rtl/rtccal_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rtccal_pkg;

    // Request and response items
    typedef struct packed {
        logic [3:0]  action;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [13:0] load_year;
    } rtc_req_t;

    typedef struct packed {
        logic [4:0] hour_now;
        logic [5:0] minute_now;
        logic [5:0] second_now;
        logic [3:0] month_now;
        logic [4:0] day_now;
        logic [6:0] year_now;
        logic [1:0] time_field_sel;
        logic [1:0] date_field_sel;
    } rtc_rsp_t;

    // Action codes as they arrive
    localparam logic [3:0] ACT_TICK      = 4'd0;
    localparam logic [3:0] ACT_LOAD      = 4'd1;
    localparam logic [3:0] ACT_TCUR_R    = 4'd2;
    localparam logic [3:0] ACT_TCUR_L    = 4'd3;
    localparam logic [3:0] ACT_TINC      = 4'd4;
    localparam logic [3:0] ACT_TDEC      = 4'd5;
    localparam logic [3:0] ACT_DCUR_R    = 4'd6;
    localparam logic [3:0] ACT_DCUR_L    = 4'd7;
    localparam logic [3:0] ACT_DINC      = 4'd8;
    localparam logic [3:0] ACT_DDEC      = 4'd9;

    // Internal operation codes after classification
    typedef logic [3:0] op_t;
    localparam op_t OP_TICK   = 4'd0;
    localparam op_t OP_LOAD   = 4'd1;
    localparam op_t OP_TCUR_R = 4'd2;
    localparam op_t OP_TCUR_L = 4'd3;
    localparam op_t OP_TINC   = 4'd4;
    localparam op_t OP_TDEC   = 4'd5;
    localparam op_t OP_DCUR_R = 4'd6;
    localparam op_t OP_DCUR_L = 4'd7;
    localparam op_t OP_DINC   = 4'd8;
    localparam op_t OP_DDEC   = 4'd9;
    localparam op_t OP_NOP    = 4'd15;

    // Cursor positions
    localparam logic [1:0] CUR_FIRST  = 2'd0;
    localparam logic [1:0] CUR_MIDDLE = 2'd1;
    localparam logic [1:0] CUR_MAX    = 2'd2;

    // Field limits
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [5:0] SEC_MAX   = 6'd59;
    localparam logic [3:0] MONTH_MIN = 4'd1;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [4:0] DAY_MIN   = 5'd1;
    localparam logic [6:0] YEAR_MAX  = 7'd99;

    // Year / 100 by reciprocal: exact for any 14-bit value
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [13:0] YEAR_BASE    = 14'd100;

    // Queue between classifier and executor
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Classified command held in the queue
    typedef struct packed {
        op_t        op;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [3:0] month;
        logic [4:0] day;
        logic [6:0] year_lo;
        logic [6:0] year_q;
    } rtc_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Days in month, no leap years; codes outside 1..12 read as January
    function automatic logic [4:0] month_days(input logic [3:0] month);
        logic [4:0] n;
        case (month)
            4'd2:    n = 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rtccal_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtccal_front (
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire rtccal_pkg::rtc_req_t req,
    input  wire rtccal_pkg::q_status_t q_status,
    output logic                      push,
    output rtccal_pkg::rtc_cmd_t      cmd
);
    import rtccal_pkg::*;

    logic [26:0] year_prod;
    logic [4:0]  load_len;

    assign req_ready = !q_status.full;
    assign push      = req_valid && !q_status.full;

    assign year_prod = 27'(req.load_year) * 27'(DIV100_MUL);

    always_comb
    begin
        cmd = '0;
        case (req.action)
            ACT_TICK:   cmd.op = OP_TICK;
            ACT_LOAD:   cmd.op = OP_LOAD;
            ACT_TCUR_R: cmd.op = OP_TCUR_R;
            ACT_TCUR_L: cmd.op = OP_TCUR_L;
            ACT_TINC:   cmd.op = OP_TINC;
            ACT_TDEC:   cmd.op = OP_TDEC;
            ACT_DCUR_R: cmd.op = OP_DCUR_R;
            ACT_DCUR_L: cmd.op = OP_DCUR_L;
            ACT_DINC:   cmd.op = OP_DINC;
            ACT_DDEC:   cmd.op = OP_DDEC;
            default:    cmd.op = OP_NOP;
        endcase

        // load operands saturated here, year remainder finished downstream
        cmd.hour   = (req.load_hour > HOUR_MAX) ? HOUR_MAX : req.load_hour;
        cmd.minute = (req.load_minute > MIN_MAX) ? MIN_MAX : req.load_minute;
        cmd.second = (req.load_second > SEC_MAX) ? SEC_MAX : req.load_second;
        if (req.load_month < MONTH_MIN)
            cmd.month = MONTH_MIN;
        else if (req.load_month > MONTH_MAX)
            cmd.month = MONTH_MAX;
        else
            cmd.month = req.load_month;

        load_len = month_days(cmd.month);

        if (req.load_day < DAY_MIN)
            cmd.day = DAY_MIN;
        else if (req.load_day > load_len)
            cmd.day = load_len;
        else
            cmd.day = req.load_day;
        cmd.year_lo = req.load_year[6:0];
        cmd.year_q  = year_prod[DIV100_SHIFT +: 7];
    end

endmodule

`default_nettype wire

@@ rtl/rtccal_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtccal_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire rtccal_pkg::rtc_cmd_t wr_data,
    input  wire logic                 pop,
    output rtccal_pkg::rtc_cmd_t      rd_data,
    output rtccal_pkg::q_status_t     status
);
    import rtccal_pkg::*;

    rtc_cmd_t            mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    assign rd_data      = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

@@ rtl/rtccal_exec.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rtccal_exec (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rtccal_pkg::rtc_cmd_t  cmd,
    input  wire rtccal_pkg::q_status_t q_status,
    output logic                       pop,
    output logic                       rsp_valid,
    input  wire logic                  rsp_ready,
    output rtccal_pkg::rtc_rsp_t       rsp
);
    import rtccal_pkg::*;

    logic [4:0] hour_reg, hour_next;
    logic [5:0] minute_reg, minute_next;
    logic [5:0] second_reg, second_next;
    logic [3:0] month_reg, month_next;
    logic [4:0] day_reg, day_next;
    logic [6:0] year_reg, year_next;
    logic [1:0] time_cursor_reg, time_cursor_next;
    logic [1:0] date_cursor_reg, date_cursor_next;
    logic       rsp_valid_reg;

    logic [13:0] year_sub;
    logic [6:0]  year_rem;
    logic [4:0]  cur_len;
    logic [4:0]  new_len;

    // remainder of year by 100; always below 128 so low bits suffice
    assign year_sub = 14'(cmd.year_q) * YEAR_BASE;
    assign year_rem = cmd.year_lo - year_sub[6:0];

    assign pop = !q_status.empty && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        month_next       = month_reg;
        day_next         = day_reg;
        year_next        = year_reg;
        time_cursor_next = time_cursor_reg;
        date_cursor_next = date_cursor_reg;
        new_len          = '0;

        if (cmd.op == OP_LOAD)
        begin
            hour_next   = cmd.hour;
            minute_next = cmd.minute;
            second_next = cmd.second;
            month_next  = cmd.month;
            day_next    = cmd.day;
            year_next   = year_rem;
        end

        cur_len = month_days(month_next);

        case (cmd.op)
            OP_TICK, OP_LOAD:
            begin
                // carry chain; day rolls only once past the month length
                if (second_next != SEC_MAX)
                    second_next = second_next + 1'b1;
                else
                begin
                    second_next = '0;
                    if (minute_next != MIN_MAX)
                        minute_next = minute_next + 1'b1;
                    else
                    begin
                        minute_next = '0;
                        if (hour_next != HOUR_MAX)
                            hour_next = hour_next + 1'b1;
                        else
                        begin
                            hour_next = '0;
                            if (day_next < cur_len)
                                day_next = day_next + 1'b1;
                            else
                            begin
                                day_next = DAY_MIN;
                                if (month_next != MONTH_MAX)
                                    month_next = month_next + 1'b1;
                                else
                                begin
                                    month_next = MONTH_MIN;
                                    year_next  = (year_next >= YEAR_MAX) ? '0
                                                 : year_next + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            OP_TCUR_R:
                time_cursor_next = (time_cursor_reg >= CUR_MAX) ? CUR_FIRST
                                   : time_cursor_reg + 1'b1;
            OP_TCUR_L:
                time_cursor_next = (time_cursor_reg == CUR_FIRST) ? CUR_MAX
                                   : time_cursor_reg - 1'b1;
            OP_TINC:
            begin
                if (time_cursor_reg == CUR_FIRST)
                    hour_next = (hour_reg >= HOUR_MAX) ? '0 : hour_reg + 1'b1;
                else if (time_cursor_reg == CUR_MIDDLE)
                    minute_next = (minute_reg >= MIN_MAX) ? '0 : minute_reg + 1'b1;
                else
                    second_next = (second_reg >= SEC_MAX) ? '0 : second_reg + 1'b1;
            end
            OP_TDEC:
            begin
                if (time_cursor_reg == CUR_FIRST)
                    hour_next = (hour_reg == '0) ? HOUR_MAX : hour_reg - 1'b1;
                else if (time_cursor_reg == CUR_MIDDLE)
                    minute_next = (minute_reg == '0) ? MIN_MAX : minute_reg - 1'b1;
                else
                    second_next = (second_reg == '0) ? SEC_MAX : second_reg - 1'b1;
            end
            OP_DCUR_R:
                date_cursor_next = (date_cursor_reg >= CUR_MAX) ? CUR_FIRST
                                   : date_cursor_reg + 1'b1;
            OP_DCUR_L:
                date_cursor_next = (date_cursor_reg == CUR_FIRST) ? CUR_MAX
                                   : date_cursor_reg - 1'b1;
            OP_DINC, OP_DDEC:
            begin
                if (date_cursor_reg == CUR_FIRST)
                begin
                    if (cmd.op == OP_DINC)
                        month_next = (month_reg >= MONTH_MAX) ? MONTH_MIN
                                     : month_reg + 1'b1;
                    else
                        month_next = (month_reg <= MONTH_MIN) ? MONTH_MAX
                                     : month_reg - 1'b1;
                    new_len = month_days(month_next);
                    if (day_reg > new_len)
                        day_next = new_len;
                end
                else if (date_cursor_reg == CUR_MIDDLE)
                begin
                    if (cmd.op == OP_DINC)
                        day_next = (day_reg >= cur_len) ? DAY_MIN : day_reg + 1'b1;
                    else
                        day_next = (day_reg <= DAY_MIN) ? cur_len : day_reg - 1'b1;
                end
                else
                begin
                    if (cmd.op == OP_DINC)
                        year_next = (year_reg >= YEAR_MAX) ? '0 : year_reg + 1'b1;
                    else
                        year_next = (year_reg == '0) ? YEAR_MAX : year_reg - 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg        <= '0;
            minute_reg      <= '0;
            second_reg      <= '0;
            month_reg       <= MONTH_MIN;
            day_reg         <= DAY_MIN;
            year_reg        <= '0;
            time_cursor_reg <= CUR_FIRST;
            date_cursor_reg <= CUR_FIRST;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                hour_reg        <= hour_next;
                minute_reg      <= minute_next;
                second_reg      <= second_next;
                month_reg       <= month_next;
                day_reg         <= day_next;
                year_reg        <= year_next;
                time_cursor_reg <= time_cursor_next;
                date_cursor_reg <= date_cursor_next;
                rsp_valid_reg   <= 1'b1;
            end
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // state only moves on a pop, and a pop only when the result slot frees,
    // so the state registers double as the result register
    assign rsp_valid          = rsp_valid_reg;
    assign rsp.hour_now       = hour_reg;
    assign rsp.minute_now     = minute_reg;
    assign rsp.second_now     = second_reg;
    assign rsp.month_now      = month_reg;
    assign rsp.day_now        = day_reg;
    assign rsp.year_now       = year_reg;
    assign rsp.time_field_sel = time_cursor_reg;
    assign rsp.date_field_sel = date_cursor_reg;

    a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
        month_reg >= MONTH_MIN && month_reg <= MONTH_MAX &&
        day_reg >= DAY_MIN && day_reg <= month_days(month_reg) &&
        year_reg <= YEAR_MAX)
        else $error("calendar state out of range");

    a_time_legal: assert property (@(posedge clk) disable iff (!rst_n)
        hour_reg <= HOUR_MAX && minute_reg <= MIN_MAX && second_reg <= SEC_MAX &&
        time_cursor_reg <= CUR_MAX && date_cursor_reg <= CUR_MAX)
        else $error("time or cursor state out of range");

    a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> rsp_valid_reg)
        else $error("executed item not presented");

    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_ready |=>
        $stable({hour_reg, minute_reg, second_reg, month_reg, day_reg, year_reg,
                 time_cursor_reg, date_cursor_reg}))
        else $error("state moved while result stalled");

endmodule

`default_nettype wire

@@ rtl/rtc_calendar_with_field_editor.sv @@
// Clock/calendar with a two-cursor field editor.
//
// Request channel (req_valid/req_ready/req): one item per action - tick,
// load, time or date cursor move, raise or lower the field under a cursor.
// Response channel (rsp_valid/rsp_ready/rsp): exactly one item per request,
// carrying the full clock state and both cursors after the action.
//
// A request is written into the queue, then into the executor state registers,
// and is shown on rsp from those registers.
// Throughput: one item per cycle while rsp_ready is high, set by the state
// update in the executor.
//
// Reset (rst_n low, asynchronous): 00:00:00, month 1, day 1, year 00,
// both cursors on their first field, queue empty, no response pending.
//
// Receiver stall: the executor holds its result while rsp_ready is low,
// the two-entry queue absorbs further requests, and req_ready drops once
// it is full.
`timescale 1ns / 1ps
`default_nettype none

module rtc_calendar_with_field_editor (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire rtccal_pkg::rtc_req_t req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output rtccal_pkg::rtc_rsp_t      rsp
);
    import rtccal_pkg::*;

    rtc_cmd_t  front_cmd;   // classified item into the queue
    rtc_cmd_t  head_cmd;    // oldest queued item
    q_status_t q_status;
    logic      push;
    logic      pop;

    // front: accept, decode action, saturate load operands, start year / 100
    rtccal_front u_front (
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_status  (q_status),
        .push      (push),
        .cmd       (front_cmd)
    );

    // decoupling queue between classifier and executor
    rtccal_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (front_cmd),
        .pop     (pop),
        .rd_data (head_cmd),
        .status  (q_status)
    );

    // back: clock state, carry chain and editor, result hold
    rtccal_exec u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .q_status  (q_status),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
